@@ hw/rtl/lmsm_pkg.sv @@
package lmsm_pkg;

  localparam int unsigned NUM_GLYPHS = 4;
  localparam int unsigned ROWS       = 8;
  localparam int unsigned COLS       = 8;
  localparam int unsigned ROW_W      = $clog2(ROWS);
  localparam int unsigned GLYPH_W    = $clog2(NUM_GLYPHS);
  localparam int unsigned BITMAP_W   = ROWS * COLS;
  localparam int unsigned CNT_W      = 4;

  localparam int unsigned GAP_COLUMNS_DEF     = 1;
  localparam int unsigned END_GAP_COLUMNS_DEF = 8;

  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 6;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned REG_LSB    = 3;

  localparam logic [CNT_W-1:0] COLUMNS_RESET = CNT_W'(COLS);

  typedef enum logic {
    FUNC_STEP = 1'b0,
    FUNC_SCAN = 1'b1
  } func_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GLYPH0_BITMAP  = 3'd0,
    REG_GLYPH1_BITMAP  = 3'd1,
    REG_GLYPH2_BITMAP  = 3'd2,
    REG_GLYPH3_BITMAP  = 3'd3,
    REG_GLYPH0_COLUMNS = 3'd4,
    REG_GLYPH1_COLUMNS = 3'd5,
    REG_GLYPH2_COLUMNS = 3'd6,
    REG_GLYPH3_COLUMNS = 3'd7
  } reg_idx_e;

  typedef enum logic [6:0] {
    PH_INIT   = 7'b0000001,
    PH_GLYPH0 = 7'b0000010,
    PH_GLYPH1 = 7'b0000100,
    PH_GLYPH2 = 7'b0001000,
    PH_GLYPH3 = 7'b0010000,
    PH_GAP    = 7'b0100000,
    PH_ENDGAP = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [NUM_GLYPHS-1:0][BITMAP_W-1:0] bitmap;
    logic [NUM_GLYPHS-1:0][CNT_W-1:0]    columns;
  } glyph_cfg_t;

endpackage

@@ hw/rtl/lmsm_if.sv @@
interface lmsm_in_if
  import lmsm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             func;
  logic [ROW_W-1:0] row_select;

  modport source (output valid, func, row_select, input ready);
  modport sink   (input valid, func, row_select, output ready);
endinterface

interface lmsm_out_if
  import lmsm_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [COLS-1:0] column_drive;
  logic [ROWS-1:0] row_drive;

  modport source (output valid, column_drive, row_drive, input ready);
  modport sink   (input valid, column_drive, row_drive, output ready);
endinterface

@@ hw/rtl/lmsm_regs.sv @@
module lmsm_regs
  import lmsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output glyph_cfg_t            cfg_o
);

  glyph_cfg_t cfg_q;
  reg_idx_e   idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[REG_LSB +: REG_IDX_W]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NUM_GLYPHS; g++) begin
        cfg_q.bitmap[g]  <= '0;
        cfg_q.columns[g] <= COLUMNS_RESET;
      end
    end else if (wr_en) begin
      unique case (idx)
        REG_GLYPH0_BITMAP:  cfg_q.bitmap[0]  <= pwdata;
        REG_GLYPH1_BITMAP:  cfg_q.bitmap[1]  <= pwdata;
        REG_GLYPH2_BITMAP:  cfg_q.bitmap[2]  <= pwdata;
        REG_GLYPH3_BITMAP:  cfg_q.bitmap[3]  <= pwdata;
        REG_GLYPH0_COLUMNS: cfg_q.columns[0] <= pwdata[CNT_W-1:0];
        REG_GLYPH1_COLUMNS: cfg_q.columns[1] <= pwdata[CNT_W-1:0];
        REG_GLYPH2_COLUMNS: cfg_q.columns[2] <= pwdata[CNT_W-1:0];
        REG_GLYPH3_COLUMNS: cfg_q.columns[3] <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_GLYPH0_BITMAP:  prdata = cfg_q.bitmap[0];
      REG_GLYPH1_BITMAP:  prdata = cfg_q.bitmap[1];
      REG_GLYPH2_BITMAP:  prdata = cfg_q.bitmap[2];
      REG_GLYPH3_BITMAP:  prdata = cfg_q.bitmap[3];
      REG_GLYPH0_COLUMNS: prdata = APB_DATA_W'(cfg_q.columns[0]);
      REG_GLYPH1_COLUMNS: prdata = APB_DATA_W'(cfg_q.columns[1]);
      REG_GLYPH2_COLUMNS: prdata = APB_DATA_W'(cfg_q.columns[2]);
      REG_GLYPH3_COLUMNS: prdata = APB_DATA_W'(cfg_q.columns[3]);
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/lmsm_seq.sv @@
module lmsm_seq
  import lmsm_pkg::*;
#(
  parameter int unsigned GAP_COLUMNS     = GAP_COLUMNS_DEF,
  parameter int unsigned END_GAP_COLUMNS = END_GAP_COLUMNS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  glyph_cfg_t      cfg_i,
  output logic [COLS-1:0] frame_o [ROWS]
);

  localparam int unsigned EXT_W = BITMAP_W + COLS;
  localparam int unsigned IDX_W = $clog2(EXT_W);

  logic [COLS-1:0]    frame_q [ROWS];
  logic [COLS-1:0]    frame_d [ROWS];
  logic [COLS-1:0]    shifted [ROWS];
  logic [COLS-1:0]    inserted [ROWS];
  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_dec;
  logic [GLYPH_W-1:0] pend_q, pend_d, cur_glyph;
  logic [EXT_W-1:0]   bitmap_ext;

  function automatic phase_e glyph_phase(logic [GLYPH_W-1:0] g);
    phase_e ph;
    unique case (g)
      2'd0:    ph = PH_GLYPH0;
      2'd1:    ph = PH_GLYPH1;
      2'd2:    ph = PH_GLYPH2;
      default: ph = PH_GLYPH3;
    endcase
    return ph;
  endfunction

  always_comb begin
    unique case (phase_q)
      PH_GLYPH1: cur_glyph = 2'd1;
      PH_GLYPH2: cur_glyph = 2'd2;
      PH_GLYPH3: cur_glyph = 2'd3;
      default:   cur_glyph = 2'd0;
    endcase
  end

  assign cnt_dec    = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
  // bit 8r+c may run past the top row; those indexes read as zero
  assign bitmap_ext = {{COLS{1'b0}}, cfg_i.bitmap[cur_glyph]};

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      shifted[r]  = {frame_q[r][COLS-2:0], 1'b0};
      inserted[r] = shifted[r]
                  | COLS'(bitmap_ext[IDX_W'(COLS * r) + IDX_W'(cnt_dec)]);
    end
  end

  always_comb begin
    frame_d = frame_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    if (step_i) begin
      unique case (phase_q)
        PH_INIT: begin
          phase_d = glyph_phase(pend_q);
          cnt_d   = cfg_i.columns[pend_q];
        end
        PH_GLYPH0, PH_GLYPH1, PH_GLYPH2, PH_GLYPH3: begin
          frame_d = inserted;
          cnt_d   = cnt_dec;
          if (cnt_dec == '0) begin
            if (cur_glyph != GLYPH_W'(NUM_GLYPHS - 1)) begin
              phase_d = PH_GAP;
              cnt_d   = CNT_W'(GAP_COLUMNS);
              pend_d  = cur_glyph + 1'b1;
            end else begin
              phase_d = PH_ENDGAP;
              cnt_d   = CNT_W'(END_GAP_COLUMNS);
            end
          end
        end
        PH_GAP: begin
          frame_d = shifted;
          cnt_d   = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d = glyph_phase(pend_q);
            cnt_d   = cfg_i.columns[pend_q];
          end
        end
        PH_ENDGAP: begin
          frame_d = shifted;
          cnt_d   = cnt_dec;
          if (cnt_dec == '0) begin
            pend_d  = '0;
            phase_d = PH_GLYPH0;
            cnt_d   = cfg_i.columns[0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) frame_q[r] <= '0;
      phase_q <= PH_INIT;
      cnt_q   <= '0;
      pend_q  <= '0;
    end else begin
      frame_q <= frame_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  assign frame_o = frame_d;

`ifndef SYNTHESIS
  // while a glyph scrolls in, the pending index names that same glyph
  a_glyph_matches_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_INIT && phase_q != PH_GAP && phase_q != PH_ENDGAP)
      |-> glyph_phase(pend_q) == phase_q)
    else $error("glyph phase and pending glyph disagree");

  a_gap_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_GAP || phase_q == PH_ENDGAP) |-> cnt_q != '0)
    else $error("gap phase with an exhausted column count");

  a_scan_holds_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(cnt_q) && $stable(pend_q))
    else $error("sequencer moved without a step");
`endif

endmodule

@@ hw/rtl/led_matrix_scroll_marquee_unit.sv @@
// A result is registered when its item is accepted; throughput is one item
// per cycle while results are taken. The sequencer step and the row lookup
// sit in a single stage between the input handshake and the result register.
// Reset (rst_ni, async, active low): frame blank, sequencer in its initial
// phase, glyph bitmaps zero, glyph column counts 8, no result pending.
module led_matrix_scroll_marquee_unit
  import lmsm_pkg::*;
#(
  parameter int unsigned GAP_COLUMNS     = GAP_COLUMNS_DEF,
  parameter int unsigned END_GAP_COLUMNS = END_GAP_COLUMNS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lmsm_in_if.sink               in_i,
  lmsm_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  glyph_cfg_t      cfg;
  logic [COLS-1:0] frame_nxt [ROWS];
  logic            in_acc;
  logic            step;
  logic            valid_q;
  logic [COLS-1:0] col_q;
  logic [ROWS-1:0] row_q;

  lmsm_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign in_i.ready = ~valid_q | out_o.ready;
  assign in_acc     = in_i.valid & in_i.ready;
  assign step       = in_acc & (in_i.func == FUNC_STEP);

  lmsm_seq #(
    .GAP_COLUMNS    (GAP_COLUMNS),
    .END_GAP_COLUMNS(END_GAP_COLUMNS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg),
    .frame_o(frame_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // drives are taken from the frame after this item's step
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q <= ~frame_nxt[in_i.row_select];
      row_q <= ~(ROWS'(1) << in_i.row_select);
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.column_drive = col_q;
  assign out_o.row_drive    = row_q;

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_o.valid)
    else $error("accepted item produced no result");

  a_row_one_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> $countones(~out_o.row_drive) == 1)
    else $error("row drive is not one-cold");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_acc)
    else $error("item accepted over an untaken result");
`endif

endmodule

@@ test/tb_led_matrix_scroll_marquee_unit.sv @@
`timescale 1ns / 1ps

module tb_led_matrix_scroll_marquee_unit
  import lmsm_pkg::*;
;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 232;

  typedef struct packed {
    logic [COLS-1:0] column_drive;
    logic [ROWS-1:0] row_drive;
  } drive_t;

  class marquee_scoreboard;
    logic [BITMAP_W-1:0] glyph_bits [NUM_GLYPHS];
    logic [CNT_W-1:0]    glyph_cols [NUM_GLYPHS];
    logic [COLS-1:0]     frame [ROWS];
    phase_e              glyph_phase [NUM_GLYPHS];
    phase_e              phase;
    logic [CNT_W-1:0]    count;
    logic [GLYPH_W-1:0]  pending;
    drive_t              drive_queue [$];
    int unsigned         errors;

    function new();
      glyph_phase = '{PH_GLYPH0, PH_GLYPH1, PH_GLYPH2, PH_GLYPH3};
      foreach (glyph_bits[g]) begin
        glyph_bits[g] = '0;
        glyph_cols[g] = COLUMNS_RESET;
      end
      foreach (frame[r]) frame[r] = '0;
      phase   = PH_INIT;
      count   = '0;
      pending = '0;
      errors  = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [APB_DATA_W-1:0] value);
      logic [REG_IDX_W-1:0] i;
      i = idx;
      if (idx <= REG_GLYPH3_BITMAP) glyph_bits[i[GLYPH_W-1:0]] = value;
      else glyph_cols[i[GLYPH_W-1:0]] = value[CNT_W-1:0];
    endfunction

    function void load_glyph(logic [GLYPH_W-1:0] g);
      phase = glyph_phase[g];
      count = glyph_cols[g];
    endfunction

    // shift the whole frame left one column, count down saturating at zero
    function void shift_and_count();
      foreach (frame[r]) frame[r] = frame[r] << 1;
      if (count != 0) count = count - 1'b1;
    endfunction

    function void scroll_step();
      int unsigned g;
      int unsigned idx;
      case (phase)
        PH_INIT: load_glyph(pending);
        PH_GLYPH0, PH_GLYPH1, PH_GLYPH2, PH_GLYPH3: begin
          g = 0;
          foreach (glyph_phase[k]) if (glyph_phase[k] == phase) g = k;
          shift_and_count();
          // column index can run past the row when the count is 8 or above
          foreach (frame[r]) begin
            idx = 8 * r + count;
            if (idx < BITMAP_W) frame[r][0] = frame[r][0] | glyph_bits[g][idx];
          end
          if (count == 0) begin
            if (g < NUM_GLYPHS - 1) begin
              phase   = PH_GAP;
              count   = CNT_W'(GAP_COLUMNS_DEF);
              pending = GLYPH_W'(g + 1);
            end else begin
              phase = PH_ENDGAP;
              count = CNT_W'(END_GAP_COLUMNS_DEF);
            end
          end
        end
        PH_GAP: begin
          shift_and_count();
          if (count == 0) load_glyph(pending);
        end
        PH_ENDGAP: begin
          shift_and_count();
          if (count == 0) begin
            pending = '0;
            load_glyph('0);
          end
        end
        default: ;
      endcase
    endfunction

    function void take_item(func_e f, logic [ROW_W-1:0] row);
      drive_t want;
      if (f == FUNC_STEP) scroll_step();
      want.column_drive = ~frame[row];
      want.row_drive    = ~(ROWS'(1) << row);
      drive_queue.push_back(want);
    endfunction

    function void flag(string what, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_drive(logic [COLS-1:0] col, logic [ROWS-1:0] rowd);
      drive_t want;
      if (drive_queue.size() == 0) begin
        flag("unexpected item column_drive", '0, col);
        return;
      end
      want = drive_queue.pop_front();
      if (col !== want.column_drive) flag("column_drive", want.column_drive, col);
      if (rowd !== want.row_drive) flag("row_drive", want.row_drive, rowd);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lmsm_in_if  in_if ();
  lmsm_out_if out_if ();

  marquee_scoreboard sb = new();

  int unsigned recv_stall_pct = 0;
  int unsigned hold_request   = 0;
  int unsigned quiet_cycles   = 0;

  logic [BITMAP_W-1:0] next_bits [NUM_GLYPHS];
  logic [CNT_W-1:0]    next_cols [NUM_GLYPHS];

  led_matrix_scroll_marquee_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.take_item(func_e'(in_if.func), in_if.row_select);
      if (out_if.valid && out_if.ready) sb.check_drive(out_if.column_drive, out_if.row_drive);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // leaves the bus selected; the caller releases it after the last write
  task automatic apb_write(input reg_idx_e idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {REG_LSB{1'b0}}};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, data);
  endtask

  task automatic write_glyph_regs();
    for (int g = 0; g < NUM_GLYPHS; g++) begin
      apb_write(reg_idx_e'(g), next_bits[g]);
      apb_write(reg_idx_e'(g + NUM_GLYPHS), APB_DATA_W'(next_cols[g]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(input func_e f, input logic [ROW_W-1:0] row,
                           input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= f;
    in_if.row_select <= row;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.drive_queue.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    int unsigned send_idle [4];
    int unsigned recv_idle [4];
    func_e f;
    send_idle = '{0, 61, 0, 14};
    recv_idle = '{0, 0, 61, 14};

    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = FUNC_STEP;
    in_if.row_select = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // blank frame under reset settings
    send_item(FUNC_SCAN, 3'd0, 0);
    send_item(FUNC_SCAN, 3'd7, 0);
    drain();

    // short glyphs: zero count saturates, last glyph runs past 8 columns
    next_bits = '{'1, 64'h8000_0000_0000_0001, 64'h0123_4567_89AB_CDEF,
                  64'hA5A5_5A5A_F00F_0FF0};
    next_cols = '{4'd0, 4'd1, 4'd2, 4'd9};
    write_glyph_regs();
    for (int i = 0; i < 20; i++) begin
      send_item(FUNC_STEP, ROW_W'(i), 0);
      if (i == 6) send_item(FUNC_SCAN, 3'd7, 0);
      if (i == 12) send_item(FUNC_SCAN, 3'd0, 0);
    end
    drain();

    for (int p = 0; p < 4; p++) begin
      for (int g = 0; g < NUM_GLYPHS; g++) begin
        case (p)
          0: begin
            next_bits[g] = {$urandom, $urandom};
            if ($urandom_range(5) == 0)
              next_cols[g] = $urandom_range(1) ? 4'd0 : CNT_W'($urandom_range(9, 15));
            else
              next_cols[g] = CNT_W'($urandom_range(1, 8));
          end
          1: begin
            next_bits[g] = '1;
            next_cols[g] = 4'd1;
          end
          2: begin
            next_bits[g] = {$urandom, $urandom};
            next_cols[g] = (g == 0) ? 4'd15 : (g == 1) ? 4'd0 : (g == 2) ? 4'd9 : 4'd8;
          end
          default: begin
            next_bits[g] = (g == 0) ? '0 : (g == 1) ? '1 : {$urandom, $urandom};
            next_cols[g] = 4'd8;
          end
        endcase
      end
      write_glyph_regs();
      recv_stall_pct = recv_idle[p];
      if (p == 0) hold_request = HOLD_CYCLES;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        f = ($urandom_range(2) == 0) ? FUNC_SCAN : FUNC_STEP;
        send_item(f, ROW_W'($urandom_range(ROWS - 1)), send_idle[p]);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
